FILE: sv/bba_pkg.sv
// Shared types, codes and width constants of the bitmap block allocator.
// No dependencies; the interfaces and the allocator top import this package.
package bba_pkg;

  localparam int OPC_W     = 3;
  localparam int BLK_W     = 16;
  localparam int CNT_W     = 17;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 1;

  // Block numbers are 16 bits wide, so at most 65536 blocks are ever managed.
  localparam int BLOCK_LIMIT = 65536;

  localparam int DEF_MAX_BLOCKS    = 65536;
  localparam int DEF_MAP_WORD_BITS = 32;

  localparam logic [CNT_W-1:0] TOTAL_RESET = CNT_W'(65536);

  typedef enum logic [OPC_W-1:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_ALLOC  = 3'd2,
    OP_FREE   = 3'd3,
    OP_FORMAT = 3'd4
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_METADATA_BLOCKS = 1'd1;

endpackage

FILE: sv/bba_ifs.sv
// Valid/ready channel interfaces of the bitmap block allocator: request,
// response and configuration write. Depends on bba_pkg for field widths.
interface bba_req_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OPC_W-1:0] opcode;
  logic [BLK_W-1:0] block_number;
  logic             bit_value;

  modport source (output valid, opcode, block_number, bit_value, input ready);
  modport sink   (input valid, opcode, block_number, bit_value, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BLK_W-1:0] result_block;
  logic             read_value;
  logic [ST_W-1:0]  status;

  modport source (output valid, result_block, read_value, status, input ready);
  modport sink   (input valid, result_block, read_value, status, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CNT_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: sv/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the usage map words of the allocator.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bba_ffz.sv
// Find-first-zero unit: isolates the lowest clear bit of a map word and
// encodes its position. Standalone, no package dependency.
module bba_ffz #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0]         word_i,
  output logic                     full_o,
  output logic [$clog2(WIDTH)-1:0] pos_o,
  output logic [WIDTH-1:0]         lowbit_o
);

  localparam int POS_W = $clog2(WIDTH);

  logic [WIDTH-1:0] low;

  // One add isolates the lowest zero; the encoder is a plain OR per bit.
  assign low      = ~word_i & (word_i + WIDTH'(1));
  assign lowbit_o = low;
  assign full_o   = &word_i;

  always_comb begin
    pos_o = '0;
    for (int k = 0; k < POS_W; k++) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (((i >> k) & 1) == 1) begin
          pos_o[k] = pos_o[k] | low[i];
        end
      end
    end
  end

endmodule

FILE: sv/bitmap_block_allocator.sv
// Bitmap first-fit block allocator. Read, write and free of an in-range block pass through
// quotient multiply, offset and map read, read-modify-write and response. Allocate reads
// and checks one map word at a time through the single map RAM read port and the
// find-first-zero unit, then writes the found bit and responds. Format writes one map word a cycle, then responds.
// After reset the map RAM is swept to zero, all MAP_WORDS words (2048 by default),
// during which no request is taken; configuration writes are taken at all times.
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int MAX_BLOCKS    = DEF_MAX_BLOCKS,
  parameter int MAP_WORD_BITS = DEF_MAP_WORD_BITS
) (
  input logic      clk_i,
  input logic      rst_ni,
  bba_req_if.sink  req,
  bba_rsp_if.source rsp,
  bba_cfg_if.sink  cfg
);

  // Map geometry.
  localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int OFF_W     = $clog2(MAP_WORD_BITS);
  localparam int MAX_EFF   = (MAX_BLOCKS < BLOCK_LIMIT) ? MAX_BLOCKS : BLOCK_LIMIT;
  localparam int SPAN_W    = $clog2(MAP_WORDS * MAP_WORD_BITS + MAP_WORD_BITS + 1);
  localparam int BASE_W    = (SPAN_W > CNT_W) ? SPAN_W : CNT_W;

  // Block-to-word split: floor(blk / MAP_WORD_BITS) by a reciprocal multiply
  // that is exact over all 16-bit block numbers.
  localparam int SHIFT  = BLK_W + OFF_W;
  localparam int RECIP  = ((1 << SHIFT) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int PROD_W = SHIFT + BLK_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIV      = 4'd1;
  localparam logic [3:0] S_ADDR     = 4'd2;
  localparam logic [3:0] S_RMW      = 4'd3;
  localparam logic [3:0] S_SCAN_RD  = 4'd4;
  localparam logic [3:0] S_SCAN_CHK = 4'd5;
  localparam logic [3:0] S_ALLOC_WR = 4'd6;
  localparam logic [3:0] S_FMT      = 4'd7;
  localparam logic [3:0] S_RESP     = 4'd8;

  // Control state.
  logic [3:0]       state_q, state_d;
  logic             init_q, init_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [CNT_W-1:0] total_q;
  logic [CNT_W-1:0] meta_q;
  logic             out_valid_q, out_valid_d;

  // Working registers of the current item.
  logic [OPC_W-1:0]         op_q, op_d;
  logic [BLK_W-1:0]         blk_q, blk_d;
  logic                     bv_q, bv_d;
  logic [CNT_W-1:0]         t_q, t_d;
  logic [BLK_W-1:0]         quo_q, quo_d;
  logic [OFF_W-1:0]         off_q, off_d;
  logic [ADDR_W-1:0]        w_q, w_d;
  logic [BASE_W-1:0]        base_q, base_d;
  logic [CNT_W-1:0]         fmeta_q, fmeta_d;
  logic [MAP_WORD_BITS-1:0] word_q, word_d;
  logic [OFF_W-1:0]         pos_q, pos_d;
  logic [MAP_WORD_BITS-1:0] low_q, low_d;
  logic [BLK_W-1:0]         res_blk_q, res_blk_d;
  logic                     res_rv_q, res_rv_d;
  status_e                  res_st_q, res_st_d;
  logic [BLK_W-1:0]         out_blk_q, out_blk_d;
  logic                     out_rv_q, out_rv_d;
  status_e                  out_st_q, out_st_d;

  // Map RAM and search unit.
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [MAP_WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic [MAP_WORD_BITS-1:0] ram_rdata;
  logic                     ffz_full;
  logic [OFF_W-1:0]         ffz_pos;
  logic [MAP_WORD_BITS-1:0] ffz_low;

  // Combinational helpers.
  logic [CNT_W-1:0]         t_eff;
  logic [PROD_W-1:0]        prod;
  logic [MAP_WORD_BITS-1:0] rmw_word;
  logic [MAP_WORD_BITS-1:0] fmt_mask;
  logic [BASE_W-1:0]        meta_ext;
  logic [BASE_W-1:0]        meta_left;
  logic [BASE_W-1:0]        alloc_blk;
  logic                     req_xfer;

  bba_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bba_ffz #(
    .WIDTH (MAP_WORD_BITS)
  ) u_ffz (
    .word_i   (ram_rdata),
    .full_o   (ffz_full),
    .pos_o    (ffz_pos),
    .lowbit_o (ffz_low)
  );

  // Effective block count: the configured total, capped by MAX_BLOCKS and the 16-bit block limit.
  assign t_eff = (total_q > CNT_W'(MAX_EFF)) ? CNT_W'(MAX_EFF) : total_q;

  assign req.ready = (state_q == S_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign rsp.valid        = out_valid_q;
  assign rsp.result_block = out_blk_q;
  assign rsp.read_value   = out_rv_q;
  assign rsp.status       = out_st_q;

  // The map port reads the addressed word in S_ADDR, else the scan word.
  assign ram_raddr = (state_q == S_ADDR) ? ADDR_W'(quo_q) : w_q;
  assign prod      = PROD_W'(blk_q) * PROD_W'(RECIP);
  assign alloc_blk = base_q + BASE_W'(pos_q);

  // Modified word for write-bit and free: set or clear one bit.
  always_comb begin
    rmw_word        = ram_rdata;
    rmw_word[off_q] = (op_q == OP_WRITE) ? bv_q : 1'b0;
  end

  // Format word: bits below the metadata bound are marked used.
  assign meta_ext  = BASE_W'(fmeta_q);
  assign meta_left = meta_ext - base_q;
  always_comb begin
    if (meta_ext <= base_q) begin
      fmt_mask = '0;
    end else if (meta_left >= BASE_W'(MAP_WORD_BITS)) begin
      fmt_mask = '1;
    end else begin
      fmt_mask = ~({MAP_WORD_BITS{1'b1}} << meta_left[OFF_W-1:0]);
    end
  end

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    free_d      = free_q;
    op_d        = op_q;
    blk_d       = blk_q;
    bv_d        = bv_q;
    t_d         = t_q;
    quo_d       = quo_q;
    off_d       = off_q;
    w_d         = w_q;
    base_d      = base_q;
    fmeta_d     = fmeta_q;
    word_d      = word_q;
    pos_d       = pos_q;
    low_d       = low_q;
    res_blk_d   = res_blk_q;
    res_rv_d    = res_rv_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !rsp.ready;
    out_blk_d   = out_blk_q;
    out_rv_d    = out_rv_q;
    out_st_d    = out_st_q;
    ram_we      = 1'b0;
    ram_waddr   = w_q;
    ram_wdata   = fmt_mask;

    case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          op_d      = req.opcode;
          blk_d     = req.block_number;
          bv_d      = req.bit_value;
          t_d       = t_eff;
          res_blk_d = '0;
          res_rv_d  = 1'b0;
          res_st_d  = ST_OK;
          w_d       = '0;
          base_d    = '0;
          case (req.opcode)
            OP_READ, OP_WRITE, OP_FREE: begin
              res_blk_d = req.block_number;
              if (CNT_W'(req.block_number) >= t_eff) begin
                res_st_d = ST_RANGE;
                state_d  = S_RESP;
              end else begin
                state_d = S_DIV;
              end
            end
            OP_ALLOC: begin
              if (free_q == '0) begin
                res_st_d = ST_NO_FREE;
                state_d  = S_RESP;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            OP_FORMAT: begin
              fmeta_d = (meta_q > t_eff) ? t_eff : meta_q;
              state_d = S_FMT;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_DIV: begin
        quo_d   = prod[SHIFT +: BLK_W];
        state_d = S_ADDR;
      end

      S_ADDR: begin
        off_d   = OFF_W'(blk_q - BLK_W'(quo_q * MAP_WORD_BITS));
        state_d = S_RMW;
      end

      S_RMW: begin
        case (op_q)
          OP_READ: begin
            res_rv_d = ram_rdata[off_q];
          end
          OP_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(quo_q);
            ram_wdata = rmw_word;
          end
          default: begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(quo_q);
            ram_wdata = rmw_word;
            if (free_q < t_q) begin
              free_d = free_q + CNT_W'(1);
            end
          end
        endcase
        state_d = S_RESP;
      end

      S_SCAN_RD: begin
        if (base_q >= BASE_W'(t_q)) begin
          res_st_d = ST_NO_FREE;
          state_d  = S_RESP;
        end else begin
          state_d = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (ffz_full) begin
          w_d     = w_q + ADDR_W'(1);
          base_d  = base_q + BASE_W'(MAP_WORD_BITS);
          state_d = S_SCAN_RD;
        end else begin
          word_d  = ram_rdata;
          pos_d   = ffz_pos;
          low_d   = ffz_low;
          state_d = S_ALLOC_WR;
        end
      end

      S_ALLOC_WR: begin
        if (alloc_blk < BASE_W'(t_q)) begin
          ram_we    = 1'b1;
          ram_wdata = word_q | low_q;
          free_d    = free_q - CNT_W'(1);
          res_blk_d = BLK_W'(alloc_blk);
        end else begin
          res_st_d = ST_NO_FREE;
        end
        state_d = S_RESP;
      end

      S_FMT: begin
        ram_we = 1'b1;
        w_d    = w_q + ADDR_W'(1);
        base_d = base_q + BASE_W'(MAP_WORD_BITS);
        if (w_q == ADDR_W'(MAP_WORDS - 1)) begin
          if (init_q) begin
            // Power-up clear done: no response, free count keeps its reset value.
            init_d  = 1'b0;
            state_d = S_IDLE;
          end else begin
            free_d  = t_q - fmeta_q;
            state_d = S_RESP;
          end
        end
      end

      S_RESP: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || rsp.ready) begin
          out_valid_d = 1'b1;
          out_blk_d   = res_blk_q;
          out_rv_d    = res_rv_q;
          out_st_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FMT;
      init_q      <= 1'b1;
      free_q      <= CNT_W'(MAX_EFF);
      out_valid_q <= 1'b0;
      w_q         <= '0;
      base_q      <= '0;
      fmeta_q     <= '0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      w_q         <= w_d;
      base_q      <= base_d;
      fmeta_q     <= fmeta_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TOTAL_RESET;
      meta_q  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        CFG_TOTAL_BLOCKS:    total_q <= cfg.wdata;
        CFG_METADATA_BLOCKS: meta_q  <= cfg.wdata;
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    blk_q     <= blk_d;
    bv_q      <= bv_d;
    t_q       <= t_d;
    quo_q     <= quo_d;
    off_q     <= off_d;
    word_q    <= word_d;
    pos_q     <= pos_d;
    low_q     <= low_d;
    res_blk_q <= res_blk_d;
    res_rv_q  <= res_rv_d;
    res_st_q  <= res_st_d;
    out_blk_q <= out_blk_d;
    out_rv_q  <= out_rv_d;
    out_st_q  <= out_st_d;
  end

`ifndef SYNTH
  // Free count never exceeds the largest possible block count.
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= CNT_W'(MAX_EFF))
    else $error("free count above block capacity");

  // The map is never written while the block waits for a request.
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("map write while idle");

  // A successful allocation takes exactly one block off the free count.
  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC_WR && ram_we) |=> (free_q == $past(free_q) - CNT_W'(1)))
    else $error("allocation did not decrement free count");

  // Leaving the response state always presents a result.
  a_resp_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && state_d == S_IDLE) |=> rsp.valid)
    else $error("response dropped");
`endif

endmodule
